>>> rtl/stable_priority_queue_assert.svh
// Assertion macros used by the queue datapath.
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/spq_pkg.sv
package spq_pkg;

    localparam int ID_W     = 16;
    localparam int PRIO_W   = 4;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t STATUS_DONE  = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

    typedef logic [1:0] rdsel_t;
    localparam rdsel_t RDSEL_FRONT = 2'd0;
    localparam rdsel_t RDSEL_LAST  = 2'd1;
    localparam rdsel_t RDSEL_PREV2 = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic    accept;
        logic    rd_en;
        rdsel_t  rd_sel;
        logic    wr_shift;
        logic    wr_insert;
        logic    deq_commit;
        logic    res_en;
        status_t res_status;
    } spq_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic pos_one;
        logic rd_greater;
    } spq_sts_t;

endpackage

>>> rtl/stable_priority_queue.sv
// Stable sorted priority queue of (task_id, task_priority) items; lower priority value
// is served first, equal priorities leave in arrival order.
// Input: an item is taken on a rising edge with start high and busy low. func selects
// enqueue (task_id/task_priority used) or dequeue (they are ignored).
// Output: one result per item, shown for a single cycle with done high; status, served
// fields (zero unless a dequeue succeeded) and occupancy after the operation.
// The receiver cannot stall; results must be sampled in the done cycle.
// Steps from the accepting edge to the result:
//   dequeue on empty or enqueue on full: result set up on acceptance, queue unchanged;
//   dequeue: one registered read of the front slot, then the result;
//   enqueue: the k stored entries that move back are shifted, one per cycle, from
//   the tail, then the new item is written; k is at most QUEUE_DEPTH - 1.
// The next item may be started in the done cycle; no item is taken while busy is high.
// Storage is a circular single-write, single-read RAM; insertion is a backward walk
// from the tail through that RAM port.
// Reset (rst_n low, asynchronous) empties the queue; RAM contents are not cleared.
module stable_priority_queue
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          func,
    input  logic [spq_pkg::ID_W-1:0]      task_id,
    input  logic [spq_pkg::PRIO_W-1:0]    task_priority,
    output logic                          done,
    output logic [spq_pkg::STATUS_W-1:0]  status,
    output logic [spq_pkg::ID_W-1:0]      served_id,
    output logic [spq_pkg::PRIO_W-1:0]    served_priority,
    output logic [spq_pkg::OCC_W-1:0]     occupancy
);

    spq_pkg::spq_cmd_t cmd;
    spq_pkg::spq_sts_t sts;

    spq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    spq_datapath
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .task_id         (task_id),
        .task_priority   (task_priority),
        .cmd             (cmd),
        .sts             (sts),
        .done            (done),
        .status          (status),
        .served_id       (served_id),
        .served_priority (served_priority),
        .occupancy       (occupancy)
    );

endmodule

>>> rtl/spq_ctrl.sv
module spq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              func,
    input  spq_pkg::spq_sts_t sts,
    output spq_pkg::spq_cmd_t cmd,
    output logic              busy
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DEQ  = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_INS  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.rd_sel     = spq_pkg::RDSEL_FRONT;
        cmd.res_status = spq_pkg::STATUS_DONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (func == spq_pkg::FUNC_DEQ)
                    begin
                        if (sts.empty)
                        begin
                            cmd.res_en     = 1'b1;
                            cmd.res_status = spq_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = spq_pkg::RDSEL_FRONT;
                            state_next = ST_DEQ;
                        end
                    end
                    else if (sts.full)
                    begin
                        cmd.res_en     = 1'b1;
                        cmd.res_status = spq_pkg::STATUS_FULL;
                    end
                    else if (sts.empty)
                    begin
                        state_next = ST_INS;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = spq_pkg::RDSEL_LAST;
                        state_next = ST_CMP;
                    end
                end
            end
            ST_DEQ:
            begin
                cmd.deq_commit = 1'b1;
                cmd.res_en     = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_CMP:
            begin
                if (sts.rd_greater)
                begin
                    cmd.wr_shift = 1'b1;
                    if (sts.pos_one)
                    begin
                        state_next = ST_INS;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = spq_pkg::RDSEL_PREV2;
                    end
                end
                else
                begin
                    cmd.wr_insert = 1'b1;
                    cmd.res_en    = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_INS:
            begin
                cmd.wr_insert = 1'b1;
                cmd.res_en    = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

>>> rtl/spq_datapath.sv
`include "stable_priority_queue_assert.svh"

module spq_datapath
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [spq_pkg::ID_W-1:0]      task_id,
    input  logic [spq_pkg::PRIO_W-1:0]    task_priority,
    input  spq_pkg::spq_cmd_t             cmd,
    output spq_pkg::spq_sts_t             sts,
    output logic                          done,
    output logic [spq_pkg::STATUS_W-1:0]  status,
    output logic [spq_pkg::ID_W-1:0]      served_id,
    output logic [spq_pkg::PRIO_W-1:0]    served_priority,
    output logic [spq_pkg::OCC_W-1:0]     occupancy
);

    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int SW    = AW + 1;
    localparam int OCC_W = spq_pkg::OCC_W;

    // circular store, slot at head_reg is the front
    spq_pkg::entry_t mem [QUEUE_DEPTH];

    spq_pkg::entry_t      item_reg;
    spq_pkg::entry_t      rd_data_reg;
    spq_pkg::entry_t      served_reg;
    spq_pkg::entry_t      wr_data;
    spq_pkg::status_t     status_reg;
    logic [OCC_W-1:0]     occ_reg;
    logic                 done_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [CW-1:0]        pos_reg;
    logic [CW-1:0]        pos_next;
    logic [AW-1:0]        head_reg;
    logic [AW-1:0]        head_next;
    logic [CW-1:0]        rd_logical;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic                 wr_en;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] idx);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(idx);
        if (sum >= SW'(QUEUE_DEPTH))
        begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    always_comb
    begin
        case (cmd.rd_sel)
            spq_pkg::RDSEL_FRONT: rd_logical = '0;
            spq_pkg::RDSEL_LAST:  rd_logical = count_reg - CW'(1);
            spq_pkg::RDSEL_PREV2: rd_logical = pos_reg - CW'(2);
            default:              rd_logical = '0;
        endcase
    end

    assign rd_addr = phys(head_reg, rd_logical);
    assign wr_addr = phys(head_reg, pos_reg);
    assign wr_en   = cmd.wr_shift | cmd.wr_insert;
    assign wr_data = cmd.wr_shift ? rd_data_reg : item_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.wr_insert)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.deq_commit)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        head_next = head_reg;
        if (cmd.deq_commit)
        begin
            head_next = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + AW'(1);
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.accept)
        begin
            pos_next = count_reg;
        end
        else if (cmd.wr_shift)
        begin
            pos_next = pos_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            head_reg  <= '0;
            pos_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            head_reg  <= head_next;
            pos_reg   <= pos_next;
            done_reg  <= cmd.res_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg.id   <= task_id;
            item_reg.prio <= task_priority;
        end
        if (cmd.res_en)
        begin
            status_reg <= cmd.res_status;
            served_reg <= cmd.deq_commit ? rd_data_reg : '0;
            occ_reg    <= OCC_W'(count_next);
        end
    end

    assign sts.empty      = (count_reg == '0);
    assign sts.full       = (count_reg == CW'(QUEUE_DEPTH));
    assign sts.pos_one    = (pos_reg == CW'(1));
    assign sts.rd_greater = (rd_data_reg.prio > item_reg.prio);

    assign done            = done_reg;
    assign status          = status_reg;
    assign served_id       = served_reg.id;
    assign served_priority = served_reg.prio;
    assign occupancy       = occ_reg;

    `SPQ_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CW'(QUEUE_DEPTH), "count beyond depth")
    `SPQ_ASSERT_NOW(a_one_write, cmd.wr_shift, !cmd.wr_insert, "shift and insert together")
    `SPQ_ASSERT_NOW(a_insert_room, cmd.wr_insert, count_reg < CW'(QUEUE_DEPTH), "insert into full store")
    `SPQ_ASSERT_NEXT(a_deq_count, cmd.deq_commit, count_reg == CW'($past(count_reg) - CW'(1)), "dequeue count slip")

endmodule

>>> tb/tb_stable_priority_queue.sv
`timescale 1ns / 100ps

module tb_stable_priority_queue;

    localparam int DEPTH      = 16;
    localparam int N_RANDOM   = 1250;
    localparam int CYCLE_CAP  = 400000;
    localparam int PRINT_CAP  = 100;

    localparam int ID_W       = spq_pkg::ID_W;
    localparam int PRIO_W     = spq_pkg::PRIO_W;
    localparam int STATUS_W   = spq_pkg::STATUS_W;
    localparam int OCC_W      = spq_pkg::OCC_W;

    typedef struct {
        logic              op;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        int                gap;
        bit                drain;
    } sched_req_t;

    typedef struct {
        spq_pkg::status_t  status;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [OCC_W-1:0]  occ;
    } sched_res_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 func = spq_pkg::FUNC_ENQ;
    logic [ID_W-1:0]      task_id = '0;
    logic [PRIO_W-1:0]    task_priority = '0;
    logic                 done;
    logic [STATUS_W-1:0]  status;
    logic [ID_W-1:0]      served_id;
    logic [PRIO_W-1:0]    served_priority;
    logic [OCC_W-1:0]     occupancy;

    // shadow of the queue contents, slot 0 is the front
    logic [ID_W-1:0]      shadow_id [DEPTH];
    logic [PRIO_W-1:0]    shadow_prio [DEPTH];
    int                   shadow_count = 0;

    sched_req_t           pending_reqs [$];
    sched_res_t           due_outcomes [$];
    sched_req_t           cur_req;
    int                   n_pushed = 0;
    int                   n_served = 0;
    int                   n_errors = 0;
    int                   wait_left = 0;
    bit                   gap_loaded = 1'b0;
    int                   cycles = 0;

    stable_priority_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .task_id(task_id),
        .task_priority(task_priority),
        .done(done),
        .status(status),
        .served_id(served_id),
        .served_priority(served_priority),
        .occupancy(occupancy)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic sched_res_t sched_update(logic op, logic [ID_W-1:0] id,
                                                logic [PRIO_W-1:0] prio);
        sched_res_t r;
        int pos;
        r.status = spq_pkg::STATUS_DONE;
        r.id = '0;
        r.prio = '0;
        if (op == spq_pkg::FUNC_DEQ)
        begin
            if (shadow_count == 0)
                r.status = spq_pkg::STATUS_EMPTY;
            else
            begin
                r.id = shadow_id[0];
                r.prio = shadow_prio[0];
                for (int i = 1; i < shadow_count; i++)
                begin
                    shadow_id[i-1] = shadow_id[i];
                    shadow_prio[i-1] = shadow_prio[i];
                end
                shadow_count--;
            end
        end
        else if (shadow_count >= DEPTH)
            r.status = spq_pkg::STATUS_FULL;
        else
        begin
            pos = 0;
            while (pos < shadow_count && shadow_prio[pos] <= prio)
                pos++;
            for (int i = shadow_count; i > pos; i--)
            begin
                shadow_id[i] = shadow_id[i-1];
                shadow_prio[i] = shadow_prio[i-1];
            end
            shadow_id[pos] = id;
            shadow_prio[pos] = prio;
            shadow_count++;
        end
        r.occ = shadow_count[OCC_W-1:0];
        return r;
    endfunction

    task automatic report(string msg);
        n_errors++;
        if (n_errors <= PRINT_CAP)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic add_req(logic op, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio,
                           int gap, bit drain);
        sched_req_t q;
        q.op = op;
        q.id = id;
        q.prio = prio;
        q.gap = gap;
        q.drain = drain;
        pending_reqs.push_back(q);
    endtask

    // driver
    always @(posedge clk)
    begin
        logic next_start;
        if (rst_n)
        begin
            next_start = start;
            if (start && !busy)
            begin
                due_outcomes.push_back(sched_update(cur_req.op, cur_req.id, cur_req.prio));
                n_pushed++;
                next_start = 1'b0;
            end
            if (!next_start && pending_reqs.size() != 0)
            begin
                if (!gap_loaded)
                begin
                    wait_left = pending_reqs[0].gap;
                    gap_loaded = 1'b1;
                end
                if (wait_left > 0)
                    wait_left--;
                else if (!(pending_reqs[0].drain && n_served != n_pushed))
                begin
                    cur_req = pending_reqs.pop_front();
                    gap_loaded = 1'b0;
                    func <= cur_req.op;
                    task_id <= cur_req.id;
                    task_priority <= cur_req.prio;
                    next_start = 1'b1;
                end
            end
            start <= next_start;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        sched_res_t e;
        if (rst_n && done)
        begin
            if (due_outcomes.size() == 0)
                report($sformatf("result with nothing pending: status %0d id %h prio %0d",
                                 status, served_id, served_priority));
            else
            begin
                e = due_outcomes.pop_front();
                if (status !== e.status)
                    report($sformatf("status %0d, want %0d", status, e.status));
                if (served_id !== e.id)
                    report($sformatf("served_id %h, want %h", served_id, e.id));
                if (served_priority !== e.prio)
                    report($sformatf("served_priority %0d, want %0d", served_priority,
                                     e.prio));
                if (occupancy !== e.occ)
                    report($sformatf("occupancy %0d, want %0d", occupancy, e.occ));
            end
            n_served <= n_served + 1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("tb_stable_priority_queue failed");
            $finish;
        end
    end

    initial
    begin
        int mode;
        int burst;
        int enq_pct;
        int prio_lo;
        int prio_hi;
        bit idle_on;
        int n_rand;
        logic op;
        logic [ID_W-1:0] rid;

        // empty dequeue, extreme fields, ties, fill to the top and overflow
        add_req(spq_pkg::FUNC_DEQ, 16'hFFFF, 4'hF, 0, 1'b0);
        add_req(spq_pkg::FUNC_ENQ, 16'h0000, 4'hF, 0, 1'b0);
        add_req(spq_pkg::FUNC_ENQ, 16'hFFFF, 4'h0, 1, 1'b0);
        add_req(spq_pkg::FUNC_ENQ, 16'h1234, 4'h7, 0, 1'b0);
        add_req(spq_pkg::FUNC_ENQ, 16'h4321, 4'h7, 2, 1'b0);
        add_req(spq_pkg::FUNC_ENQ, 16'hAAAA, 4'h7, 0, 1'b0);
        add_req(spq_pkg::FUNC_ENQ, 16'h5555, 4'h0, 3, 1'b0);
        add_req(spq_pkg::FUNC_ENQ, 16'hBEEF, 4'hF, 0, 1'b0);
        for (int i = 0; i < 9; i++)
            add_req(spq_pkg::FUNC_ENQ, ID_W'(16'h1111 * (i + 1)), i[PRIO_W-1:0] + 4'd3,
                    $urandom_range(0, 2), 1'b0);
        add_req(spq_pkg::FUNC_ENQ, 16'hFFFF, 4'h0, 0, 1'b0);
        add_req(spq_pkg::FUNC_DEQ, 16'h0000, 4'h0, 0, 1'b1);
        for (int i = 0; i < 4; i++)
            add_req(spq_pkg::FUNC_DEQ, ID_W'($urandom_range(0, 65535)),
                    PRIO_W'($urandom_range(0, 15)), $urandom_range(0, 3), 1'b0);

        n_rand = 0;
        while (n_rand < N_RANDOM)
        begin
            mode = $urandom_range(0, 3);
            burst = $urandom_range(8, 60);
            case (mode)
                0: enq_pct = 85;
                1: enq_pct = 15;
                2: enq_pct = 50;
                default: enq_pct = $urandom_range(0, 100);
            endcase
            if (mode != 3 && $urandom_range(0, 1) == 1)
            begin
                prio_lo = $urandom_range(0, 13);
                prio_hi = prio_lo + 2;
            end
            else
            begin
                prio_lo = 0;
                prio_hi = 15;
            end
            idle_on = ($urandom_range(0, 2) != 0);
            for (int k = 0; k < burst; k++)
            begin
                op = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::FUNC_ENQ
                                                       : spq_pkg::FUNC_DEQ;
                if ($urandom_range(0, 9) == 0)
                    rid = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0;
                else
                    rid = ID_W'($urandom_range(0, 65535));
                add_req(op, rid, PRIO_W'($urandom_range(prio_lo, prio_hi)),
                        idle_on ? $urandom_range(0, 13) : 0,
                        (n_rand == 0) || ($urandom_range(0, 199) == 0));
                n_rand++;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || start || n_served != n_pushed);
        repeat (40) @(negedge clk);

        if (due_outcomes.size() != 0)
            report($sformatf("%0d results never arrived", due_outcomes.size()));
        if (n_errors == 0)
            $display("tb_stable_priority_queue passed");
        else
            $display("tb_stable_priority_queue failed");
        $finish;
    end

endmodule
